### rtl/photon_time_window_ranges_core_macros.svh
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef PHOTON_TIME_WINDOW_RANGES_CORE_MACROS_SVH
`define PHOTON_TIME_WINDOW_RANGES_CORE_MACROS_SVH

// same-cycle implication
`define PTWR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ptwr_pkg.sv
`timescale 1ns / 1ps
package ptwr_pkg;

    localparam int RANGE_W = 31;
    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 5;

    typedef enum logic [2:0] {
        REG_WINDOW_MIN = 3'd0,
        REG_WINDOW_MAX = 3'd1,
        REG_PHOTONS_MIN = 3'd2,
        REG_PHOTONS_MAX = 3'd3,
        REG_INVERT      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [RANGE_W-1:0] range_begin;
        logic [RANGE_W-1:0] range_end;
        logic               last_of_run;
    } t_result;

endpackage

### rtl/photon_time_window_ranges_core.sv
`timescale 1ns / 1ps
// Channel   | Dir | tdata (low bit up)                      | tlast
// ----------+-----+-----------------------------------------+--------------
// s (in)    | in  | photon time, zero pad to bytes          | end_of_stream
// m (out)   | out | range_begin, range_end, 2 zero pad bits | last_of_run
// apb       | in  | five 32-bit registers at 4*i            | -
//
// One input word is taken per cycle while the result buffer has room; its windows
// are worked out in one pass from the input register into a two-entry result buffer.
// A word that selects two windows makes the next word wait in the input register,
// since the result port drains one word per cycle while i_m_tready is high.
// A stalled result port holds the input register; one more word may wait in it.
// Reset is synchronous, active low, and restores register defaults and state.
`include "photon_time_window_ranges_core_macros.svh"
module photon_time_window_ranges_core
    import ptwr_pkg::*;
#(
    parameter int INDEX_BITS = 31,
    parameter int TIME_BITS  = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((TIME_BITS+7)/8)*8-1:0]      i_s_tdata,   // photon time
    input  logic                                i_s_tlast,   // end_of_stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [63:0]                         o_m_tdata,   // range_begin, range_end
    output logic                                o_m_tlast,   // last_of_run
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ADDR_W-1:0]                   paddr,
    input  logic [CFG_W-1:0]                    pwdata,
    output logic [CFG_W-1:0]                    prdata,
    output logic                                pready
);

    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [CFG_W-1:0]        r_wmin;
    logic [CFG_W-1:0]        r_wmax;
    logic signed [CFG_W-1:0] r_pmin;
    logic signed [CFG_W-1:0] r_pmax;
    logic                    r_invert;

    logic                    r_in_v;
    logic [TIME_BITS-1:0]    r_in_t;
    logic                    r_in_eos;

    logic                    r_open;
    logic [INDEX_BITS-1:0]   r_sidx;
    logic [TIME_BITS-1:0]    r_stime;
    logic [INDEX_BITS-1:0]   r_pidx;

    logic [1:0]              r_cnt;
    t_result                 r_res [2];

    logic                    n_open;
    logic [INDEX_BITS-1:0]   n_sidx;
    logic [TIME_BITS-1:0]    n_stime;
    logic [INDEX_BITS-1:0]   n_pidx;
    logic [1:0]              n_cnt;
    t_result                 n_res [2];

    logic                    cfg_wr;
    t_reg_idx                cfg_idx;
    logic                    pop;
    logic                    out_free;
    logic                    proc;
    logic [TIME_BITS-1:0]    span1;
    logic [CW-1:0]           span1_x;
    logic [CW-1:0]           span2_x;
    logic [CW-1:0]           minlen_x;
    logic                    close1;
    logic                    restart;
    logic [INDEX_BITS-1:0]   idx_next;
    logic [INDEX_BITS-1:0]   begin2;
    logic                    sel1;
    logic                    sel2;
    t_result                 res1;
    t_result                 res2;

    function automatic logic keep(input logic [CW-1:0] span,
                                  input logic [INDEX_BITS-1:0] count,
                                  input logic [CFG_W-1:0] wmax,
                                  input logic signed [CFG_W-1:0] pmin,
                                  input logic signed [CFG_W-1:0] pmax,
                                  input logic invert);
        logic             ok;
        logic [CFG_W-1:0] cnt_x;
        cnt_x = CFG_W'(count);
        ok = 1'b1;
        if ((wmax != '0) && !(span < CW'(wmax))) begin
            ok = 1'b0;
        end
        if (!pmin[CFG_W-1] && (cnt_x < unsigned'(pmin))) begin
            ok = 1'b0;
        end
        if (!pmax[CFG_W-1] && (cnt_x > unsigned'(pmax))) begin
            ok = 1'b0;
        end
        return ok ^ invert;
    endfunction

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wmin   <= CFG_W'(1);
            r_wmax   <= '0;
            r_pmin   <= '1;
            r_pmax   <= '1;
            r_invert <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WINDOW_MIN:  r_wmin   <= pwdata;
                REG_WINDOW_MAX:  r_wmax   <= pwdata;
                REG_PHOTONS_MIN: r_pmin   <= signed'(pwdata);
                REG_PHOTONS_MAX: r_pmax   <= signed'(pwdata);
                REG_INVERT:      r_invert <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WINDOW_MIN:  prdata = r_wmin;
            REG_WINDOW_MAX:  prdata = r_wmax;
            REG_PHOTONS_MIN: prdata = unsigned'(r_pmin);
            REG_PHOTONS_MAX: prdata = unsigned'(r_pmax);
            REG_INVERT:      prdata = CFG_W'(r_invert);
            default:         prdata = '0;
        endcase
    end

    // handshake
    assign pop        = o_m_tvalid && i_m_tready;
    assign out_free   = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_m_tready);
    assign proc       = r_in_v && out_free;
    assign o_s_tready = !r_in_v || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_v <= 1'b1;
        end else if (proc) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_t   <= i_s_tdata[TIME_BITS-1:0];
            r_in_eos <= i_s_tlast;
        end
    end

    // window logic
    assign span1    = r_in_t - r_stime;
    assign span1_x  = CW'(span1);
    assign minlen_x = (r_wmin == '0) ? CW'(1) : CW'(r_wmin);
    assign close1   = r_open && (span1_x >= minlen_x);
    assign restart  = !r_open || close1;
    assign span2_x  = restart ? '0 : span1_x;
    assign idx_next = r_pidx + INDEX_BITS'(1);
    assign begin2   = restart ? r_pidx : r_sidx;

    assign sel1 = close1 && keep(span1_x, r_pidx - r_sidx, r_wmax, r_pmin, r_pmax, r_invert);
    assign sel2 = r_in_eos
                  && keep(span2_x, idx_next - begin2, r_wmax, r_pmin, r_pmax, r_invert);

    always_comb begin
        res1.range_begin = RANGE_W'(32'(r_sidx));
        res1.range_end   = RANGE_W'(32'(r_pidx));
        res1.last_of_run = !sel2;
        res2.range_begin = RANGE_W'(32'(begin2));
        res2.range_end   = RANGE_W'(32'(idx_next));
        res2.last_of_run = 1'b1;
    end

    always_comb begin
        n_open  = r_open;
        n_sidx  = r_sidx;
        n_stime = r_stime;
        n_pidx  = r_pidx;
        if (proc) begin
            if (r_in_eos) begin
                n_open  = 1'b0;
                n_sidx  = '0;
                n_stime = '0;
                n_pidx  = '0;
            end else begin
                n_open = 1'b1;
                n_pidx = idx_next;
                if (restart) begin
                    n_sidx  = r_pidx;
                    n_stime = r_in_t;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_sidx  <= '0;
            r_stime <= '0;
            r_pidx  <= '0;
        end else begin
            r_open  <= n_open;
            r_sidx  <= n_sidx;
            r_stime <= n_stime;
            r_pidx  <= n_pidx;
        end
    end

    // result buffer, head in entry 0
    always_comb begin
        n_cnt    = r_cnt;
        n_res[0] = r_res[0];
        n_res[1] = r_res[1];
        if (proc) begin
            n_cnt    = 2'(sel1) + 2'(sel2);
            n_res[0] = sel1 ? res1 : res2;
            n_res[1] = res2;
        end else if (pop) begin
            n_cnt    = r_cnt - 2'd1;
            n_res[0] = r_res[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res[0] <= n_res[0];
        r_res[1] <= n_res[1];
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = {2'b00, r_res[0].range_end, r_res[0].range_begin};
    assign o_m_tlast  = r_res[0].last_of_run;

    `PTWR_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt != 2'd3, "result count out of range")
    `PTWR_ASSERT_NOW(a_no_overwrite, r_cnt == 2'd2, !proc, "pending pair overwritten")
    `PTWR_ASSERT_NOW(a_pair_head, r_cnt == 2'd2, !r_res[0].last_of_run, "pair head last")
    `PTWR_ASSERT_NOW(a_pair_tail, r_cnt == 2'd2, r_res[1].last_of_run, "pair tail not last")
    `PTWR_ASSERT_NEXT(a_eos_clears, proc && r_in_eos, !r_open && r_pidx == '0, "end not cleared")
    `PTWR_ASSERT_NEXT(a_held_word, r_in_v && !proc, r_in_v, "held input word lost")

endmodule

### tb/sv/photon_time_window_ranges_core_tb.sv
`timescale 1ns / 1ps
module photon_time_window_ranges_core_tb;
    import ptwr_pkg::*;

    localparam int LIMIT      = 600000;
    localparam int RAND_WORDS = 1450;

    typedef struct {
        logic [31:0] wmin;
        logic [31:0] wmax;
        logic [31:0] pmin;
        logic [31:0] pmax;
        bit          inv;
    } t_settings;

    // n < 0: windows come from the window model, else r0/r1 are typed in
    typedef struct {
        logic [63:0] mtime;
        bit          eos;
        int          cfg;
        int          n;
        t_result     r0;
        t_result     r1;
    } t_photon;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata  = '0;   // photon time
    logic        i_s_tlast  = 1'b0; // end_of_stream
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;         // range_begin, range_end, 2 zero bits
    logic        o_m_tlast;         // last_of_run
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr  = '0;
    logic [CFG_W-1:0]  pwdata = '0;
    logic [CFG_W-1:0]  prdata;
    logic        pready;

    photon_time_window_ranges_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    int      errors = 0;
    int      cycles = 0;
    int      tx_mode = 1;
    bit      rx_mode = 1'b1;
    int      rx_hold = 0;

    // sideband that travels with the driven word
    int      drv_n = -1;
    t_result drv_r0 = '0;
    t_result drv_r1 = '0;

    // window model state and settings
    logic [31:0] cfg_wmin = 32'd1;
    logic [31:0] cfg_wmax = 32'd0;
    logic [31:0] cfg_pmin = 32'hFFFF_FFFF;
    logic [31:0] cfg_pmax = 32'hFFFF_FFFF;
    bit          cfg_inv  = 1'b0;
    bit          win_open = 1'b0;
    logic [30:0] win_b    = '0;
    logic [63:0] win_t    = '0;
    logic [30:0] ph_idx   = '0;
    t_result     fresh[2];
    int          fresh_n;
    t_result     win_q[$];

    t_settings   dir_set[4];
    t_photon     dir_rows[$];

    function automatic void judge_window(logic [30:0] b, logic [30:0] e, logic [63:0] span);
        logic [30:0] cnt;
        bit          sel;
        cnt = e - b;
        sel = 1'b1;
        if (cfg_wmax != 0 && !(span < {32'd0, cfg_wmax})) sel = 1'b0;
        if (!cfg_pmin[31] && {1'b0, cnt} < cfg_pmin) sel = 1'b0;
        if (!cfg_pmax[31] && {1'b0, cnt} > cfg_pmax) sel = 1'b0;
        if (cfg_inv) sel = !sel;
        if (sel) begin
            fresh[fresh_n] = '{b, e, 1'b0};
            fresh_n++;
        end
    endfunction

    function automatic void step_photon(logic [63:0] t, bit eos);
        logic [63:0] span;
        logic [31:0] minlen;
        logic [30:0] idx;
        idx     = ph_idx;
        minlen  = (cfg_wmin == 0) ? 32'd1 : cfg_wmin;
        fresh_n = 0;
        if (!win_open) begin
            win_open = 1'b1;
            win_b    = idx;
            win_t    = t;
        end else begin
            span = t - win_t;
            if (span >= {32'd0, minlen}) begin
                judge_window(win_b, idx, span);
                win_b = idx;
                win_t = t;
            end
        end
        if (eos) begin
            span = t - win_t;
            judge_window(win_b, idx + 31'd1, span);
            win_open = 1'b0;
            win_b    = '0;
            win_t    = '0;
            ph_idx   = '0;
        end else begin
            ph_idx = idx + 31'd1;
        end
        if (fresh_n > 0) fresh[fresh_n-1].last_of_run = 1'b1;
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    function automatic void add_row(logic [63:0] t, bit eos, int cfg, int n,
                                    int b0 = 0, int e0 = 0, int b1 = 0, int e1 = 0);
        t_photon w;
        w.mtime = t;
        w.eos   = eos;
        w.cfg   = cfg;
        w.n     = n;
        w.r0    = '{31'(b0), 31'(e0), n == 1};
        w.r1    = '{31'(b1), 31'(e1), 1'b1};
        dir_rows.insert(dir_rows.size(), w);
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                step_photon(i_s_tdata, i_s_tlast);
                if (drv_n >= 0) begin
                    if (drv_n > 0) win_q.insert(win_q.size(), drv_r0);
                    if (drv_n > 1) win_q.insert(win_q.size(), drv_r1);
                end else begin
                    for (int k = 0; k < fresh_n; k++) win_q.insert(win_q.size(), fresh[k]);
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                got = '{o_m_tdata[30:0], o_m_tdata[61:31], o_m_tlast};
                if (win_q.size() == 0) begin
                    $display("%0t: unexpected word begin %0d end %0d last %0d",
                             $time, got.range_begin, got.range_end, got.last_of_run);
                    errors++;
                end else begin
                    want = win_q.pop_front();
                    check_field("range_begin", 32'(want.range_begin), 32'(got.range_begin));
                    check_field("range_end", 32'(want.range_end), 32'(got.range_end));
                    check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
                end
            end
        end
    end

    always @(posedge i_clk) begin : rx_side
        int r;
        if (rx_hold > 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (!rx_mode) begin
            i_m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                i_m_tready <= 1'b1;
            end else if (r < 97) begin
                i_m_tready <= 1'b0;
                rx_hold    <= $urandom_range(0, 2);
            end else begin
                i_m_tready <= 1'b0;
                rx_hold    <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("photon_time_window_ranges_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_photon(t_photon w);
        int gap;
        int r;
        gap = 0;
        if (tx_mode != 0) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(8, 40);
            else if (r >= 70) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= w.mtime;
        i_s_tlast  <= w.eos;
        drv_n      <= w.n;
        drv_r0     <= w.r0;
        drv_r1     <= w.r1;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // idle out: wait for every expected word back and for words with no window to pass through
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (win_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (r)
            REG_WINDOW_MIN:  cfg_wmin = v;
            REG_WINDOW_MAX:  cfg_wmax = v;
            REG_PHOTONS_MIN: cfg_pmin = v;
            REG_PHOTONS_MAX: cfg_pmax = v;
            REG_INVERT:      cfg_inv  = v[0];
            default: ;
        endcase
    endtask

    task automatic load_settings(t_settings s);
        write_reg(REG_WINDOW_MIN, s.wmin);
        write_reg(REG_WINDOW_MAX, s.wmax);
        write_reg(REG_PHOTONS_MIN, s.pmin);
        write_reg(REG_PHOTONS_MAX, s.pmax);
        write_reg(REG_INVERT, {31'd0, s.inv});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : main
        t_settings   s;
        t_photon     w;
        int          sent;
        int          n;
        int          strm_left;
        logic [63:0] t_now;
        logic [63:0] inc;
        logic [31:0] wm;

        dir_set[0] = '{32'd3, 32'd10, 32'd2, 32'd3, 1'b0};
        dir_set[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF9, 1'b1};
        dir_set[2] = '{32'd1, 32'd0, 32'h7FFF_FFFF, 32'd0, 1'b1};
        dir_set[3] = '{32'd1, 32'd1, 32'd0, 32'h7FFF_FFFF, 1'b0};

        // reset settings: min length 1, no limits, no inversion
        add_row(64'd0, 1'b1, -1, 1, 0, 1);
        add_row(64'd5, 1'b0, -1, 0);
        add_row(64'd5, 1'b0, -1, 0);
        add_row(64'd6, 1'b0, -1, 1, 0, 2);
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, -1, 2, 2, 3, 3, 4);
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, -1, 0);
        add_row(64'd0, 1'b0, -1, 1, 0, 1);
        add_row(64'd3, 1'b1, -1, 2, 1, 2, 2, 3);
        add_row(64'd100, 1'b0, 0, -1);
        add_row(64'd101, 1'b0, -1, -1);
        add_row(64'd102, 1'b0, -1, -1);
        add_row(64'd103, 1'b0, -1, -1);
        add_row(64'd120, 1'b0, -1, -1);
        add_row(64'd121, 1'b0, -1, -1);
        add_row(64'd122, 1'b1, -1, -1);
        add_row(64'd0, 1'b0, 1, -1);
        add_row(64'h1_0000_0000, 1'b0, -1, -1);
        add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, -1, -1);
        add_row(64'd7, 1'b0, 2, -1);
        add_row(64'd7, 1'b1, -1, -1);
        add_row(64'd1, 1'b1, 3, -1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg >= 0) begin
                drain();
                load_settings(dir_set[dir_rows[i].cfg]);
            end
            send_photon(dir_rows[i]);
        end

        sent      = 0;
        strm_left = 0;
        t_now     = '0;
        w.n       = -1;
        w.cfg     = -1;
        w.r0      = '0;
        w.r1      = '0;
        while (sent < RAND_WORDS) begin
            drain();
            case ($urandom_range(0, 9))
                0:       s.wmin = 32'hFFFF_FFFF;
                1:       s.wmin = 32'd1;
                2:       s.wmin = $urandom_range(1, 1000);
                3:       s.wmin = $urandom | 32'd1;
                default: s.wmin = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 9))
                0:       s.wmax = 32'hFFFF_FFFF;
                1:       s.wmax = $urandom;
                2, 3:    s.wmax = s.wmin + $urandom_range(0, 40);
                4:       s.wmax = $urandom_range(1, 30);
                default: s.wmax = 32'd0;
            endcase
            case ($urandom_range(0, 9))
                0:       s.pmin = 32'h7FFF_FFFF;
                1:       s.pmin = $urandom | 32'h8000_0000;
                2:       s.pmin = $urandom;
                3, 4, 5: s.pmin = $urandom_range(0, 6);
                default: s.pmin = 32'hFFFF_FFFF;
            endcase
            case ($urandom_range(0, 9))
                0:       s.pmax = 32'h7FFF_FFFF;
                1:       s.pmax = $urandom | 32'h8000_0000;
                2, 3, 4: s.pmax = $urandom_range(0, 10);
                default: s.pmax = 32'hFFFF_FFFF;
            endcase
            s.inv = ($urandom_range(0, 3) == 0);
            load_settings(s);
            tx_mode = $urandom_range(0, 3);
            rx_mode <= ($urandom_range(0, 3) != 0);
            wm = cfg_wmin;
            n  = $urandom_range(30, 120);
            for (int k = 0; k < n; k++) begin
                if (strm_left == 0) begin
                    strm_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                                            : $urandom_range(1, 25);
                    case ($urandom_range(0, 3))
                        0: t_now = {$urandom, $urandom};
                        1: t_now = '0;
                        2: t_now = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 50));
                        default: t_now = 64'($urandom_range(0, 1000));
                    endcase
                end else begin
                    case ($urandom_range(0, 15))
                        0, 1, 2:    inc = '0;
                        3, 4, 5, 6: inc = 64'($urandom_range(0, wm));
                        7:          inc = {32'd0, wm} - 64'd1;
                        8, 9:       inc = {32'd0, wm};
                        10:         inc = {32'd0, wm} + 64'd1;
                        11, 12:     inc = {32'd0, wm} + 64'($urandom_range(0, wm));
                        13:         inc = {$urandom, $urandom};
                        default:    inc = 64'($urandom_range(0, 3));
                    endcase
                    t_now = t_now + inc;
                end
                w.mtime = t_now;
                w.eos   = (strm_left == 1) || ($urandom_range(0, 49) == 0);
                send_photon(w);
                strm_left = w.eos ? 0 : strm_left - 1;
                sent++;
            end
        end
        drain();
        repeat (20) @(posedge i_clk);

        if (errors == 0 && win_q.size() == 0)
            $display("photon_time_window_ranges_core_tb: done, clean");
        else
            $display("photon_time_window_ranges_core_tb: done, errors");
        $finish;
    end

endmodule
